// File: src/svf_lowpass_filter_unit_defines.svh
// assertion macros for the state variable lowpass filter
// used by src/svf_lowpass_filter_unit.sv, no other dependencies
`ifndef SVF_LOWPASS_FILTER_UNIT_DEFINES_SVH
`define SVF_LOWPASS_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define SVF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/svf_lpf_pkg.sv
// package for the state variable lowpass filter
// configuration register indexes used by the top level, and their width, shared with the cfg interface
package svf_lpf_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_A1 = 2'd0,
        COEF_A2 = 2'd1,
        COEF_A3 = 2'd2
    } t_coef_idx;

endpackage

// File: src/svf_lpf_if.sv
// valid/ready channel interfaces of the state variable lowpass filter
// depends on svf_lpf_pkg for the register index width
interface svf_lpf_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           block_end_in;

    modport source (output valid, output sample_in, output block_end_in, input ready);
    modport sink   (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface svf_lpf_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           block_end_out;

    modport source (output valid, output sample_out, output block_end_out, input ready);
    modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

interface svf_lpf_cfg_if #(
    parameter int DATA_WIDTH = 19
);
    logic                                valid;
    logic                                ready;
    logic [svf_lpf_pkg::CFG_IDX_W-1:0]   index;
    logic [DATA_WIDTH-1:0]               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/svf_lowpass_filter_unit.sv
// trapezoidal state variable lowpass filter, top level
// depends on svf_lpf_pkg, svf_lpf_if.sv and svf_lowpass_filter_unit_defines.svh
//
// usage:
//   i_in   : sample items (sample_in, block_end_in), valid/ready
//   o_out  : result items (sample_out, block_end_out), valid/ready
//   i_cfg  : coefficient writes, index 0..2 selects a1, a2, a3; other
//            indexes are ignored; always ready, write only while idle
//   an accepted item lands in the input register, the whole filter update
//   is done between that register and the output register, so a result
//   is offered once the item has moved on into the output register
//   throughput is one item per cycle while the receiver does not stall,
//   as the recursive update of the two integrator states is combinational
//   reset clears both states and loads a1 = 1.0, a2 = a3 = 0
//   when the receiver stalls the result holds in the output register,
//   one more item is taken into the input register, then ready drops
//   block_end is passed along with its sample; states carry across blocks
`include "svf_lowpass_filter_unit_defines.svh"

module svf_lowpass_filter_unit #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 18,
    parameter int GUARD_BITS     = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    svf_lpf_in_if.sink    i_in,
    svf_lpf_out_if.source o_out,
    svf_lpf_cfg_if.sink   i_cfg
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int STW = SAMPLE_WIDTH + GUARD_BITS;
    localparam int FB  = COEF_FRAC_BITS;
    localparam int CW  = COEF_FRAC_BITS + 1;
    localparam int PW  = STW + CW + 5;

    localparam logic signed [PW-1:0] ONE    = PW'(1);
    localparam logic signed [PW-1:0] HALF   = ONE <<< (FB - 1);
    localparam logic signed [PW-1:0] ST_MAX = (ONE <<< (STW - 1)) - ONE;
    localparam logic signed [PW-1:0] ST_MIN = -ST_MAX - ONE;
    localparam logic signed [PW-1:0] SM_MAX = (ONE <<< (SW - 1)) - ONE;
    localparam logic signed [PW-1:0] SM_MIN = -SM_MAX - ONE;
    localparam logic [CW-1:0]        COEF_ONE = CW'(1) << FB;

    logic [CW-1:0]           r_coef_a1;
    logic [CW-1:0]           r_coef_a2;
    logic [CW-1:0]           r_coef_a3;
    logic signed [STW-1:0]   r_state_one;
    logic signed [STW-1:0]   r_state_two;
    logic signed [STW-1:0]   n_state_one;
    logic signed [STW-1:0]   n_state_two;

    logic                    r_in_valid;
    logic signed [SW-1:0]    r_x;
    logic                    r_be;
    logic                    r_out_valid;
    logic signed [SW-1:0]    r_sample_out;
    logic                    r_be_out;
    logic signed [SW-1:0]    n_sample_out;

    logic                    w_move;
    logic signed [STW:0]     w_v3;
    logic signed [CW+STW:0]   w_m_a1s1;
    logic signed [CW+STW:0]   w_m_a2s1;
    logic signed [CW+STW+1:0] w_m_a2v3;
    logic signed [CW+STW+1:0] w_m_a3v3;
    logic signed [PW-1:0]    w_p1;
    logic signed [PW-1:0]    w_p2;
    logic signed [PW-1:0]    w_n1;
    logic signed [PW-1:0]    w_n2;
    logic signed [PW-1:0]    w_r1;
    logic signed [PW-1:0]    w_r2;
    logic signed [PW-1:0]    w_ry;

    // handshakes
    assign w_move      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_move;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.sample_out    = r_sample_out;
    assign o_out.block_end_out = r_be_out;

    // filter update
    always_comb begin
        w_v3 = {{(GUARD_BITS + 1){r_x[SW-1]}}, r_x} - {r_state_two[STW-1], r_state_two};

        w_m_a1s1 = (CW+STW+1)'($signed({1'b0, r_coef_a1})) * (CW+STW+1)'(r_state_one);
        w_m_a2s1 = (CW+STW+1)'($signed({1'b0, r_coef_a2})) * (CW+STW+1)'(r_state_one);
        w_m_a2v3 = (CW+STW+2)'($signed({1'b0, r_coef_a2})) * (CW+STW+2)'(w_v3);
        w_m_a3v3 = (CW+STW+2)'($signed({1'b0, r_coef_a3})) * (CW+STW+2)'(w_v3);

        w_p1 = PW'(w_m_a1s1) + PW'(w_m_a2v3);
        w_p2 = (PW'(r_state_two) <<< FB) + PW'(w_m_a2s1) + PW'(w_m_a3v3);
        w_n1 = (w_p1 <<< 1) - (PW'(r_state_one) <<< FB);
        w_n2 = (w_p2 <<< 1) - (PW'(r_state_two) <<< FB);

        w_ry = (w_p2 + HALF) >>> FB;
        w_r1 = (w_n1 + HALF) >>> FB;
        w_r2 = (w_n2 + HALF) >>> FB;

        if (w_ry > SM_MAX) begin
            n_sample_out = SW'(SM_MAX);
        end else if (w_ry < SM_MIN) begin
            n_sample_out = SW'(SM_MIN);
        end else begin
            n_sample_out = w_ry[SW-1:0];
        end

        if (w_r1 > ST_MAX) begin
            n_state_one = STW'(ST_MAX);
        end else if (w_r1 < ST_MIN) begin
            n_state_one = STW'(ST_MIN);
        end else begin
            n_state_one = w_r1[STW-1:0];
        end

        if (w_r2 > ST_MAX) begin
            n_state_two = STW'(ST_MAX);
        end else if (w_r2 < ST_MIN) begin
            n_state_two = STW'(ST_MIN);
        end else begin
            n_state_two = w_r2[STW-1:0];
        end
    end

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a1 <= COEF_ONE;
            r_coef_a2 <= '0;
            r_coef_a3 <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (svf_lpf_pkg::t_coef_idx'(i_cfg.index))
                svf_lpf_pkg::COEF_A1: r_coef_a1 <= i_cfg.data;
                svf_lpf_pkg::COEF_A2: r_coef_a2 <= i_cfg.data;
                svf_lpf_pkg::COEF_A3: r_coef_a3 <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // control and integrator states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state_one <= '0;
            r_state_two <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_state_one <= n_state_one;
                r_state_two <= n_state_two;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_x  <= i_in.sample_in;
            r_be <= i_in.block_end_in;
        end
        if (w_move) begin
            r_sample_out <= n_sample_out;
            r_be_out     <= r_be;
        end
    end

    `SVF_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !w_move,
        $stable(r_state_one) && $stable(r_state_two), "states changed without an item")
    `SVF_ASSERT_SAME(a_ready_low, i_clk, i_rst_n, !i_in.ready,
        r_in_valid && r_out_valid && !o_out.ready, "input stalled while a stage is free")
    `SVF_ASSERT_NEXT(a_move_out, i_clk, i_rst_n, w_move,
        r_out_valid, "item lost between input and output register")
    `SVF_ASSERT_NEXT(a_cfg_a1, i_clk, i_rst_n,
        i_cfg.valid && i_cfg.ready && i_cfg.index == svf_lpf_pkg::COEF_A1,
        r_coef_a1 == $past(i_cfg.data), "coefficient a1 write lost")

endmodule
